>>> rtl/mtcw_pkg.sv
// Shared types and constants for the multi-terminal text console writer.
// No dependencies; every other file of the block imports this package.
package mtcw_pkg;

  localparam int ADDR_W = 14;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int VIEW_W = 5;
  localparam int TERM_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  // Screen geometry
  localparam logic [ADDR_W-1:0] ROW_CELLS   = 14'd80;
  localparam logic [ROW_W-1:0]  ROW_MAX     = 6'd63;
  localparam logic [ROW_W-1:0]  VIEW_ROWS   = 6'd25;
  localparam logic [ROW_W-1:0]  VIEW_BOTTOM = 6'd24;
  localparam logic [ROW_W-1:0]  VIEW_MAX    = 6'd31;

  // Character and request codes
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
  localparam logic              MODE_SWITCH  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LINE_COUNT  = 2'd1;
  localparam logic [1:0] REG_TEXT_COLOUR = 2'd2;

  // Reset values of the configuration registers
  localparam logic [COL_W-1:0]  LINE_WIDTH_RST  = 7'd80;
  localparam logic [ROW_W-1:0]  LINE_COUNT_RST  = 6'd50;
  localparam logic [ATTR_W-1:0] TEXT_COLOUR_RST = 8'd15;

  typedef struct packed {
    logic              mode;
    logic [TERM_W-1:0] term;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              start_valid;
    logic [ADDR_W-1:0] start_offset;
    logic              cursor_valid;
    logic [ADDR_W-1:0] cursor_pos;
  } out_item_t;

  // One terminal's entry in the state memory
  typedef struct packed {
    logic [VIEW_W-1:0] view;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } entry_t;

  typedef struct packed {
    logic [COL_W-1:0]  line_width;
    logic [ROW_W-1:0]  line_count;
    logic [ATTR_W-1:0] text_colour;
  } cfg_t;

  // Result of the update stage, before address formation
  typedef struct packed {
    logic              cell_write;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              start_valid;
    logic [VIEW_W-1:0] start_view;
    logic              cursor_valid;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [TERM_W-1:0] term;
  } res_t;

endpackage

>>> rtl/mtcw_if.sv
// Valid/ready channel interfaces for console requests and results.
// Depends on mtcw_pkg for the payload structs.
interface mtcw_in_if;
  import mtcw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtcw_out_if;
  import mtcw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/multi_terminal_text_console_writer.sv
// Text console writer for up to TERMINALS virtual terminals sharing one
// character memory. It takes one request per clock cycle unless the output
// stalls; each gives exactly one result via the request register and the
// output register. Per-terminal cursor and view state sits in a small memory
// with one read and one write port: a request reads its terminal's entry on
// acceptance, updates and writes it back as it leaves the request register,
// and a request that follows one for the same terminal takes the written
// value directly. Results wait in the output register, so a stalled consumer
// holds at most two requests in flight before the request side stalls. Depends
// on mtcw_pkg, mtcw_if, mtcw_state_ram, mtcw_cfg, mtcw_update and mtcw_format.
module multi_terminal_text_console_writer #(
  parameter int TERMINALS      = 4,
  parameter int TERMINAL_CELLS = 4000
) (
  input  logic        clk,
  input  logic        rst,
  mtcw_in_if.sink     item,
  mtcw_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtcw_pkg::*;

  localparam int AW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  cfg_t              cfg;
  logic              acc;
  logic              s1_v;
  in_item_t          s1_item;
  logic              s1_fire;
  logic              s2_v;
  res_t              s2_res;
  logic              fwd_v;
  entry_t            fwd_entry;
  entry_t            ram_rdata;
  entry_t            cur;
  entry_t            upd_entry;
  logic              upd_we;
  logic [TERM_W-1:0] shown;
  logic [TERM_W-1:0] shown_next;
  res_t              upd_res;
  logic              in_term_ok;

  mtcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: stage 1 moves on when the output register is free or drains
  assign s1_fire    = s1_v && (!s2_v || result.ready);
  assign item.ready = !s1_v || s1_fire;
  assign acc        = item.valid && item.ready;
  assign in_term_ok = {1'b0, item.data.term} < (TERM_W + 1)'(TERMINALS);

  mtcw_state_ram #(
    .DEPTH  (TERMINALS),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .ren   (acc && in_term_ok),
    .raddr (item.data.term[AW-1:0]),
    .rdata (ram_rdata),
    .wen   (s1_fire && upd_we),
    .waddr (s1_item.term[AW-1:0]),
    .wdata (upd_entry)
  );

  // Stage 1 state comes from the write of the previous request when it matched
  assign cur = fwd_v ? fwd_entry : ram_rdata;

  mtcw_update #(
    .TERMINALS (TERMINALS)
  ) u_update (
    .item       (s1_item),
    .cur        (cur),
    .cfg        (cfg),
    .shown      (shown),
    .entry      (upd_entry),
    .we         (upd_we),
    .shown_next (shown_next),
    .res        (upd_res)
  );

  // Stage 1: request register and forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      fwd_v <= 1'b0;
    end else if (acc) begin
      s1_v  <= 1'b1;
      fwd_v <= s1_fire && upd_we && (s1_item.term == item.data.term);
    end else if (s1_fire) begin
      s1_v  <= 1'b0;
      fwd_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item   <= item.data;
      fwd_entry <= upd_entry;
    end
  end

  // Shown terminal
  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
    end else if (s1_fire) begin
      shown <= shown_next;
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_fire) begin
      s2_v <= 1'b1;
    end else if (result.ready) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_res <= upd_res;
    end
  end

  assign result.valid = s2_v;

  mtcw_format #(
    .TERMINAL_CELLS (TERMINAL_CELLS)
  ) u_format (
    .res  (s2_res),
    .item (result.data)
  );

endmodule

>>> rtl/mtcw_state_ram.sv
// Per-terminal cursor/view state memory: one read port, one write port,
// registered read data. Entries never written read as zero. Uses mtcw_pkg.
module mtcw_state_ram #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ren,
  input  logic [ADDR_W-1:0]    raddr,
  output mtcw_pkg::entry_t     rdata,
  input  logic                 wen,
  input  logic [ADDR_W-1:0]    waddr,
  input  mtcw_pkg::entry_t     wdata
);
  import mtcw_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld;
  entry_t           rd_q;
  logic             rd_vld;

  // Storage array
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rd_q <= mem[raddr];
    end
  end

  // Written flags, cleared by reset so that state starts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wen) begin
        vld[waddr] <= 1'b1;
      end
      if (ren) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

>>> rtl/mtcw_cfg.sv
// APB-style configuration registers: line width, line count, text colour.
// Uses mtcw_pkg for register indexes, reset values and the cfg_t struct.
module mtcw_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output mtcw_pkg::cfg_t cfg
);
  import mtcw_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width  <= LINE_WIDTH_RST;
      cfg.line_count  <= LINE_COUNT_RST;
      cfg.text_colour <= TEXT_COLOUR_RST;
    end else if (wr) begin
      unique case (idx)
        REG_LINE_WIDTH:  cfg.line_width  <= pwdata[COL_W-1:0];
        REG_LINE_COUNT:  cfg.line_count  <= pwdata[ROW_W-1:0];
        REG_TEXT_COLOUR: cfg.text_colour <= pwdata[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_LINE_WIDTH:  prdata = {{(32-COL_W){1'b0}}, cfg.line_width};
      REG_LINE_COUNT:  prdata = {{(32-ROW_W){1'b0}}, cfg.line_count};
      REG_TEXT_COLOUR: prdata = {{(32-ATTR_W){1'b0}}, cfg.text_colour};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/mtcw_update.sv
// Cursor update for one request: advances the addressed terminal's entry,
// handles newline, wrap, scroll and terminal switch. Uses mtcw_pkg.
module mtcw_update #(
  parameter int TERMINALS = 4
) (
  input  mtcw_pkg::in_item_t          item,
  input  mtcw_pkg::entry_t            cur,
  input  mtcw_pkg::cfg_t              cfg,
  input  logic [mtcw_pkg::TERM_W-1:0] shown,
  output mtcw_pkg::entry_t            entry,
  output logic                        we,
  output logic [mtcw_pkg::TERM_W-1:0] shown_next,
  output mtcw_pkg::res_t              res
);
  import mtcw_pkg::*;

  logic             term_ok;
  logic [ROW_W-1:0] vdiff;

  assign term_ok = {1'b0, item.term} < (TERM_W + 1)'(TERMINALS);

  always_comb begin
    entry      = cur;
    we         = 1'b0;
    shown_next = shown;
    res        = '0;
    res.term   = item.term;
    vdiff      = '0;
    if (term_ok) begin
      if (item.mode == MODE_SWITCH) begin
        // Switch: new display start at the terminal base, report its cursor
        if (item.term != shown) begin
          shown_next       = item.term;
          res.start_valid  = 1'b1;
          res.cursor_valid = 1'b1;
          res.cur_row      = cur.row;
          res.cur_col      = cur.col;
        end
      end else begin
        we = 1'b1;
        if (item.char_code == CHAR_NEWLINE) begin
          entry.col = '0;
          if (entry.row < ROW_MAX) entry.row = entry.row + 1'b1;
        end else if (item.char_code != CHAR_NUL) begin
          // Wrap the column, then the row, then write the cell
          if (entry.col >= cfg.line_width) begin
            entry.col = '0;
            if (entry.row < ROW_MAX) entry.row = entry.row + 1'b1;
          end
          if (entry.row >= cfg.line_count) entry.row = '0;
          res.cell_write = 1'b1;
          res.cell_row   = entry.row;
          res.cell_col   = entry.col;
          res.cell_char  = item.char_code;
          res.cell_attr  = cfg.text_colour;
          entry.col      = entry.col + 1'b1;
        end
        // End of string: scroll view if needed and report cursor if shown
        if (item.last_char) begin
          if (entry.row >= VIEW_ROWS) begin
            vdiff           = entry.row - VIEW_BOTTOM;
            entry.view      = (vdiff > VIEW_MAX) ? VIEW_MAX[VIEW_W-1:0] : vdiff[VIEW_W-1:0];
            res.start_valid = 1'b1;
            res.start_view  = entry.view;
          end
          if (item.term == shown) begin
            res.cursor_valid = 1'b1;
            res.cur_row      = entry.row;
            res.cur_col      = entry.col;
          end
        end
      end
    end
  end

endmodule

>>> rtl/mtcw_format.sv
// Forms cell, display start and cursor addresses from a registered update
// result: base + row * 80 + column, 14-bit wrap. Uses mtcw_pkg.
module mtcw_format #(
  parameter int TERMINAL_CELLS = 4000
) (
  input  mtcw_pkg::res_t    res,
  output mtcw_pkg::out_item_t item
);
  import mtcw_pkg::*;

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] cursor_addr;

  // Terminal base is a small constant multiply
  assign base = ADDR_W'(32'(res.term) * TERMINAL_CELLS);

  assign cell_addr   = base + ADDR_W'(res.cell_row) * ROW_CELLS + ADDR_W'(res.cell_col);
  assign start_addr  = base + ADDR_W'(res.start_view) * ROW_CELLS;
  assign cursor_addr = base + ADDR_W'(res.cur_row) * ROW_CELLS + ADDR_W'(res.cur_col);

  // Fields of inactive parts read as zero
  always_comb begin
    item              = '0;
    item.cell_write   = res.cell_write;
    item.start_valid  = res.start_valid;
    item.cursor_valid = res.cursor_valid;
    if (res.cell_write) begin
      item.cell_address = cell_addr;
      item.cell_char    = res.cell_char;
      item.cell_attr    = res.cell_attr;
    end
    if (res.start_valid) begin
      item.start_offset = start_addr;
    end
    if (res.cursor_valid) begin
      item.cursor_pos = cursor_addr;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for multi_terminal_text_console_writer: random and
// directed console requests, predicted results compared in order.
// Depends on mtcw_pkg, mtcw_if and the RTL of the console writer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtcw_pkg::*;

  localparam int NUM_TERMS    = 4;
  localparam int CELLS_PER_TERM = 4000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int STALL_LIMIT  = 1000;

  // Tracks per-terminal cursor state and holds the results still owed by the DUT
  class console_tracker;
    logic [COL_W-1:0]  line_width;
    logic [ROW_W-1:0]  line_count;
    logic [ATTR_W-1:0] text_colour;
    logic [COL_W-1:0]  col_of[NUM_TERMS];
    logic [ROW_W-1:0]  row_of[NUM_TERMS];
    logic [VIEW_W-1:0] view_of[NUM_TERMS];
    logic [TERM_W-1:0] shown_term;
    out_item_t         expected_results[$];
    int                mismatch_count;

    function new();
      line_width  = LINE_WIDTH_RST;
      line_count  = LINE_COUNT_RST;
      text_colour = TEXT_COLOUR_RST;
      for (int t = 0; t < NUM_TERMS; t++) begin
        col_of[t]  = '0;
        row_of[t]  = '0;
        view_of[t] = '0;
      end
      shown_term     = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_LINE_WIDTH:  line_width  = value[COL_W-1:0];
        REG_LINE_COUNT:  line_count  = value[ROW_W-1:0];
        REG_TEXT_COLOUR: text_colour = value[ATTR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ADDR_W-1:0] cell_of(int t, int unsigned row, int unsigned col);
      int unsigned a;
      a = t * CELLS_PER_TERM + row * 80 + col;
      return a[ADDR_W-1:0];
    endfunction

    // Row advance saturates at the top of the row counter
    function void next_row(int t);
      if (row_of[t] < ROW_MAX) row_of[t] = row_of[t] + 1'b1;
    endfunction

    function out_item_t console_step(in_item_t r);
      out_item_t   o;
      int          t;
      int unsigned v;
      o = '0;
      t = int'(r.term);
      if (t >= NUM_TERMS) return o;

      // Switch: show another terminal from its base, report its cursor
      if (r.mode == MODE_SWITCH) begin
        if (r.term == shown_term) return o;
        shown_term     = r.term;
        o.start_valid  = 1'b1;
        o.start_offset = cell_of(t, 0, 0);
        o.cursor_valid = 1'b1;
        o.cursor_pos   = cell_of(t, 32'(row_of[t]), 32'(col_of[t]));
        return o;
      end

      // Put: newline, empty string or ordinary character
      if (r.char_code == CHAR_NEWLINE) begin
        col_of[t] = '0;
        next_row(t);
      end else if (r.char_code != CHAR_NUL) begin
        if (col_of[t] >= line_width) begin
          col_of[t] = '0;
          next_row(t);
        end
        if (row_of[t] >= line_count) row_of[t] = '0;
        o.cell_write   = 1'b1;
        o.cell_address = cell_of(t, 32'(row_of[t]), 32'(col_of[t]));
        o.cell_char    = r.char_code;
        o.cell_attr    = text_colour;
        col_of[t]      = col_of[t] + 1'b1;
      end

      // End of string: scroll the view if needed, report the cursor if shown
      if (r.last_char) begin
        if (row_of[t] >= VIEW_ROWS) begin
          v = 32'(row_of[t]) - 32'(VIEW_BOTTOM);
          if (v > 32'(VIEW_MAX)) v = 32'(VIEW_MAX);
          view_of[t]     = v[VIEW_W-1:0];
          o.start_valid  = 1'b1;
          o.start_offset = cell_of(t, v, 0);
        end
        if (r.term == shown_term) begin
          o.cursor_valid = 1'b1;
          o.cursor_pos   = cell_of(t, 32'(row_of[t]), 32'(col_of[t]));
        end
      end
      return o;
    endfunction

    function void note_request(in_item_t r);
      expected_results.push_back(console_step(r));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %p", $time, got);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("cell_write",   32'(want.cell_write),   32'(got.cell_write));
      compare_field("cell_address", 32'(want.cell_address), 32'(got.cell_address));
      compare_field("cell_char",    32'(want.cell_char),    32'(got.cell_char));
      compare_field("cell_attr",    32'(want.cell_attr),    32'(got.cell_attr));
      compare_field("start_valid",  32'(want.start_valid),  32'(got.start_valid));
      compare_field("start_offset", 32'(want.start_offset), 32'(got.start_offset));
      compare_field("cursor_valid", 32'(want.cursor_valid), 32'(got.cursor_valid));
      compare_field("cursor_pos",   32'(want.cursor_pos),   32'(got.cursor_pos));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mtcw_in_if  req_if();
  mtcw_out_if res_if();

  console_tracker tracker = new();
  bit             no_idle;
  int             items_sent;
  int             idle_cycles;

  multi_terminal_text_console_writer #(
    .TERMINALS      (NUM_TERMS),
    .TERMINAL_CELLS (CELLS_PER_TERM)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (req_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic in_item_t put_item(int t, logic [CHAR_W-1:0] c, logic last);
    in_item_t r;
    r.mode      = ~MODE_SWITCH;
    r.term      = t[TERM_W-1:0];
    r.char_code = c;
    r.last_char = last;
    return r;
  endfunction

  function automatic in_item_t switch_item(int t, logic [CHAR_W-1:0] c, logic last);
    in_item_t r;
    r      = put_item(t, c, last);
    r.mode = MODE_SWITCH;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(1, 255));
    if (c == CHAR_NEWLINE) c = 8'h20;
    return c;
  endfunction

  function automatic int pick_between(int lo, int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Present one request, hold it until accepted
  task automatic send_request(in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (!(r.mode == MODE_SWITCH && r.term == tracker.shown_term)) items_sent++;
    tracker.note_request(r);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk);
  endtask

  // Stop requests and wait for every owed result
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // A string of text for one terminal, closed by last_char
  task automatic send_string();
    int                t;
    int                len;
    int                p;
    logic [CHAR_W-1:0] c;
    t   = $urandom_range(0, NUM_TERMS - 1);
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    for (int i = 0; i < len; i++) begin
      p = $urandom_range(0, 99);
      if (p < 15) c = CHAR_NEWLINE;
      else if (p < 18) c = CHAR_NUL;
      else c = pick_char();
      send_request(put_item(t, c, i == len - 1));
    end
  endtask

  // Run of newlines that pushes the cursor row toward the scroll region
  task automatic send_newline_run();
    int t;
    int n;
    t = $urandom_range(0, NUM_TERMS - 1);
    n = $urandom_range(5, 30);
    repeat (n) send_request(put_item(t, CHAR_NEWLINE, 1'b0));
    send_request(put_item(t, pick_char(), 1'b1));
  endtask

  task automatic send_random_group();
    int               r;
    logic [11:0]      bits;
    r = $urandom_range(0, 99);
    if (r < 60) send_string();
    else if (r < 70) send_newline_run();
    else if (r < 78) send_request(put_item($urandom_range(0, NUM_TERMS - 1), CHAR_NUL, 1'b1));
    else if (r < 88)
      send_request(switch_item($urandom_range(0, NUM_TERMS - 1),
                               CHAR_W'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1))));
    else begin
      bits = 12'($urandom_range(0, 4095));
      send_request(in_item_t'(bits));
    end
  endtask

  // Result side: random stalls, check each accepted result
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      tracker.check_result(res_if.data);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int w;
    int n;
    int a;
    int phase_start;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    no_idle      = 1'b0;
    items_sent   = 0;
    idle_cycles  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cursor report, empty string, hidden terminal, switches
    send_request(put_item(0, 8'h48, 1'b0));
    send_request(put_item(0, 8'hFF, 1'b1));
    send_request(put_item(0, CHAR_NUL, 1'b1));
    send_request(put_item(1, CHAR_NEWLINE, 1'b1));
    send_request(put_item(1, 8'h01, 1'b1));
    send_request(switch_item(1, 8'hAA, 1'b1));
    send_request(switch_item(1, 8'h55, 1'b0));
    send_request(put_item(1, 8'h80, 1'b1));
    send_request(switch_item(3, CHAR_NUL, 1'b0));
    send_request(put_item(3, 8'h7F, 1'b1));
    send_request(put_item(3, CHAR_NEWLINE, 1'b0));
    send_request(put_item(2, 8'h7A, 1'b1));
    send_request(switch_item(2, 8'hFF, 1'b1));
    send_request(put_item(2, CHAR_NUL, 1'b0));
    send_request(switch_item(0, CHAR_NEWLINE, 1'b0));
    // Saturate a row at the top: 63 newlines on terminal 3, the last one
    // closing a string so the view clamps, then a put
    repeat (62) send_request(put_item(3, CHAR_NEWLINE, 1'b0));
    send_request(put_item(3, CHAR_NEWLINE, 1'b1));
    send_request(put_item(3, pick_char(), 1'b1));
    repeat (4) send_newline_run();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase == 0) begin
        w = 1;  n = 50; a = 0;
      end else if (phase == 1) begin
        w = 80; n = 1;  a = 255;
      end else if (phase == 2) begin
        w = 80; n = 50; a = 15;
      end else begin
        w = pick_between(1, 80);
        n = pick_between(1, 50);
        a = pick_between(0, 255);
      end
      write_register(REG_LINE_WIDTH, w);
      write_register(REG_LINE_COUNT, n);
      write_register(REG_TEXT_COLOUR, a);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 7) == 0);
        send_random_group();
      end
    end

    // Wait for the last results, then a short tail for strays
    drain_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
